// File: sv/rational_arithmetic_unit_defines.svh
// Assertion macros for the rational arithmetic unit.
// No dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAU_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define RAU_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define RAU_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// File: sv/rau_pkg.sv
// Package for the rational arithmetic unit: widths and mode codes.
// No dependencies.
package rau_pkg;
    localparam int OperandWidth = 16;
    localparam int ProdWidth = 2 * OperandWidth;
    localparam int ValWidth = ProdWidth + 2;
    localparam int CntWidth = $clog2(ValWidth + 1);

    localparam logic [3:0] MODE_ADD = 4'd0;
    localparam logic [3:0] MODE_SUB = 4'd1;
    localparam logic [3:0] MODE_MUL = 4'd2;
    localparam logic [3:0] MODE_DIV = 4'd3;
    localparam logic [3:0] MODE_LT  = 4'd4;
    localparam logic [3:0] MODE_GT  = 4'd5;
    localparam logic [3:0] MODE_LE  = 4'd6;
    localparam logic [3:0] MODE_GE  = 4'd7;
    localparam logic [3:0] MODE_EQ  = 4'd8;
    localparam logic [3:0] MODE_NE  = 4'd9;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;
endpackage

// File: sv/rau_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  rau_pkg::div_ctl_t              ctl_in,
    input  logic [rau_pkg::ValWidth-1:0]   dividend,
    input  logic [rau_pkg::ValWidth-1:0]   divisor,
    output logic [rau_pkg::ValWidth-1:0]   quotient,
    output logic [rau_pkg::ValWidth-1:0]   remainder,
    output logic                           done
);
    logic [rau_pkg::ValWidth-1:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [rau_pkg::CntWidth-1:0] cnt_reg, cnt_next;
    logic                         run_reg, run_next, done_reg, done_next;
    logic [rau_pkg::ValWidth:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[rau_pkg::ValWidth-1]} - {1'b0, d_reg};
        if (ctl_in.start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = rau_pkg::CntWidth'(rau_pkg::ValWidth);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // shift one dividend bit in, subtract when it fits
            if (!trial[rau_pkg::ValWidth])
            begin
                r_next = trial[rau_pkg::ValWidth-1:0];
                q_next = {q_reg[rau_pkg::ValWidth-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[rau_pkg::ValWidth-2:0], q_reg[rau_pkg::ValWidth-1]};
                q_next = {q_reg[rau_pkg::ValWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rau_pkg::CntWidth'(1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient = q_reg;
    assign remainder = r_reg;
    assign done = done_reg;
endmodule

// File: sv/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer around one divider.
// Depends on rau_pkg, rau_div and rational_arithmetic_unit_defines.svh.
//
// An item is taken when start is high and busy is low. Compare modes, errors,
// unused modes and zero results pass from the product state through the form
// state straight to the output state. Arithmetic modes form the raw fraction
// with two products (cross products but in multiply mode), find the gcd by
// Euclid's algorithm on the shared restoring divider (each remainder step is a
// start, 34 quotient bits and a done; at most about 46 steps on 31-bit
// magnitudes), then divide numerator and denominator by the gcd on the same
// divider. Busy time is set by the number of remainder steps. The result shows
// for one cycle with valid high; the receiver cannot stall it, so take it then.
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [3:0]                              mode,
    input  logic signed [rau_pkg::OperandWidth-1:0] a_num,
    input  logic [rau_pkg::OperandWidth-2:0]        a_den,
    input  logic signed [rau_pkg::OperandWidth-1:0] b_num,
    input  logic [rau_pkg::OperandWidth-2:0]        b_den,
    output logic                                    valid,
    output logic signed [31:0]                      res_num,
    output logic [30:0]                             res_den,
    output logic                                    cmp_true,
    output logic                                    error
);
    localparam int VW = rau_pkg::ValWidth;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PROD = 3'd1;
    localparam logic [2:0] ST_FORM = 3'd2;
    localparam logic [2:0] ST_GCD  = 3'd3;
    localparam logic [2:0] ST_DIVN = 3'd4;
    localparam logic [2:0] ST_DIVD = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [3:0] mode_reg;
    logic signed [rau_pkg::OperandWidth-1:0] an_reg, bn_reg;
    logic signed [rau_pkg::OperandWidth:0]   ad_reg, bd_reg;
    logic signed [VW-1:0] lhs_reg, rhs_reg, dd_reg;
    logic [VW-1:0] un_reg, ud_reg, x_reg, y_reg, qn_reg;
    logic neg_reg, wait_reg;
    logic signed [VW-1:0] raw_n, raw_d;
    logic [VW-1:0] div_a, div_b, quo, rem;
    logic div_done;
    rau_pkg::div_ctl_t dctl;
    logic signed [31:0] rn_reg;
    logic [30:0] rd_reg;
    logic ct_reg, er_reg, valid_reg;
    logic bad_den;

    rau_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (dctl),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (quo),
        .remainder(rem),
        .done     (div_done)
    );

    assign bad_den = (ad_reg == '0) || (bd_reg == '0);
    assign busy = (state_reg != ST_IDLE);

    // raw fraction before reduction
    always_comb
    begin
        raw_n = lhs_reg + rhs_reg;
        raw_d = dd_reg;
        case (mode_reg)
            rau_pkg::MODE_SUB: raw_n = lhs_reg - rhs_reg;
            rau_pkg::MODE_MUL: raw_n = lhs_reg;
            rau_pkg::MODE_DIV: raw_n = lhs_reg;
            default: raw_n = lhs_reg + rhs_reg;
        endcase
    end

    always_comb
    begin
        dctl.start = 1'b0;
        dctl.done = div_done;
        div_a = x_reg;
        div_b = y_reg;
        if (state_reg == ST_DIVN || state_reg == ST_DIVD)
        begin
            div_a = (state_reg == ST_DIVN) ? un_reg : ud_reg;
            div_b = x_reg;
        end
        if (wait_reg) dctl.start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == ST_OUT);
            wait_reg <= 1'b0;
            if ((state_next == ST_GCD && (state_reg != ST_GCD || dctl.done))
                || (state_next == ST_DIVN && state_reg != ST_DIVN)
                || (state_next == ST_DIVD && state_reg != ST_DIVD))
                wait_reg <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_PROD;
            ST_PROD: state_next = ST_FORM;
            ST_FORM:
            begin
                if (mode_reg > rau_pkg::MODE_DIV || bad_den
                    || (mode_reg == rau_pkg::MODE_DIV && bn_reg == '0)
                    || raw_n == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_GCD;
            end
            ST_GCD:
                if (div_done && rem == '0) state_next = ST_DIVN;
            ST_DIVN: if (div_done) state_next = ST_DIVD;
            ST_DIVD: if (div_done) state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mode_reg <= mode;
                an_reg <= a_num;
                bn_reg <= b_num;
                ad_reg <= {2'b00, a_den};
                bd_reg <= {2'b00, b_den};
            end
            ST_PROD:
            begin
                // one multiplier per operand pair, registered
                if (mode_reg == rau_pkg::MODE_MUL)
                    lhs_reg <= VW'(an_reg * bn_reg);
                else
                    lhs_reg <= VW'(an_reg * bd_reg);
                rhs_reg <= VW'(bn_reg * ad_reg);
                dd_reg <= (mode_reg == rau_pkg::MODE_DIV)
                    ? VW'(ad_reg * $signed({bn_reg[rau_pkg::OperandWidth-1], bn_reg}))
                    : VW'(ad_reg * bd_reg);
            end
            ST_FORM:
            begin
                neg_reg <= raw_n[VW-1] ^ raw_d[VW-1];
                un_reg <= raw_n[VW-1] ? -raw_n : raw_n;
                ud_reg <= raw_d[VW-1] ? -raw_d : raw_d;
                x_reg <= raw_n[VW-1] ? -raw_n : raw_n;
                y_reg <= raw_d[VW-1] ? -raw_d : raw_d;
                rn_reg <= '0;
                if (mode_reg <= rau_pkg::MODE_NE && bad_den)
                begin
                    er_reg <= 1'b1;
                    ct_reg <= 1'b0;
                    rd_reg <= '0;
                end
                else
                begin
                    er_reg <= (mode_reg == rau_pkg::MODE_DIV) && (bn_reg == '0);
                    case (mode_reg)
                        rau_pkg::MODE_LT: ct_reg <= (lhs_reg < rhs_reg);
                        rau_pkg::MODE_GT: ct_reg <= (lhs_reg > rhs_reg);
                        rau_pkg::MODE_LE: ct_reg <= (lhs_reg <= rhs_reg);
                        rau_pkg::MODE_GE: ct_reg <= (lhs_reg >= rhs_reg);
                        rau_pkg::MODE_EQ: ct_reg <= (lhs_reg == rhs_reg);
                        rau_pkg::MODE_NE: ct_reg <= (lhs_reg != rhs_reg);
                        default: ct_reg <= 1'b0;
                    endcase
                    // zero arithmetic result reads as 0/1
                    rd_reg <= (mode_reg <= rau_pkg::MODE_DIV && raw_n == '0
                               && !(mode_reg == rau_pkg::MODE_DIV && bn_reg == '0))
                              ? 31'd1 : 31'd0;
                end
            end
            ST_GCD:
                // Euclid step: advance (x, y) to (y, x mod y); on a zero remainder x takes y, the gcd
                if (div_done)
                begin
                    if (rem == '0)
                        x_reg <= y_reg;
                    else
                    begin
                        x_reg <= y_reg;
                        y_reg <= rem;
                    end
                end
            ST_DIVN: if (div_done) qn_reg <= quo;
            ST_DIVD:
                if (div_done)
                begin
                    rn_reg <= neg_reg ? -qn_reg[31:0] : qn_reg[31:0];
                    rd_reg <= quo[30:0];
                end
            default: ;
        endcase
    end

    assign valid = valid_reg;
    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign cmp_true = ct_reg;
    assign error = er_reg;

    `RAU_ASSERT_NEXT(a_out_idle, clk, rst_n, state_reg == ST_OUT, valid_reg && !busy, "result while still busy")
    `RAU_ASSERT_IMPL(a_err_clean, clk, rst_n, (valid_reg && er_reg) |-> (rn_reg == '0 && rd_reg == '0 && !ct_reg), "error with nonzero result")
    `RAU_ASSERT_IMPL(a_ct_arith, clk, rst_n, (valid_reg && mode_reg <= rau_pkg::MODE_DIV) |-> !ct_reg, "compare bit in arithmetic mode")
endmodule

// File: verif/rational_arithmetic_unit_checker.sv
// Checker for the rational arithmetic unit: predicts each result from the
// accepted item and compares it with the strobed output. Depends on rau_pkg.
module rational_arithmetic_unit_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic                                    busy,
    input  logic [3:0]                              mode,
    input  logic signed [rau_pkg::OperandWidth-1:0] a_num,
    input  logic [rau_pkg::OperandWidth-2:0]        a_den,
    input  logic signed [rau_pkg::OperandWidth-1:0] b_num,
    input  logic [rau_pkg::OperandWidth-2:0]        b_den,
    input  logic                                    valid,
    input  logic signed [31:0]                      res_num,
    input  logic [30:0]                             res_den,
    input  logic                                    cmp_true,
    input  logic                                    error,
    input  logic                                    finish_check,
    output int                                      fail_count,
    output int                                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        cmp;
        logic        err;
    } fraction_result_t;

    fraction_result_t expected_results[$];
    bit               leftovers_reported;

    assign pending = expected_results.size();

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Sign to the numerator, lowest terms, zero as 0/1.
    function automatic fraction_result_t normalize(longint n, longint d);
        fraction_result_t r;
        bit              neg;
        longint unsigned un;
        longint unsigned ud;
        longint unsigned g;
        r = '0;
        neg = (n < 0) ^ (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        if (un == 0)
        begin
            r.den = 31'd1;
            return r;
        end
        g = euclid_gcd(un, ud);
        un = un / g;
        ud = ud / g;
        r.num = 32'(neg ? -un : un);
        r.den = ud[30:0];
        return r;
    endfunction

    function automatic fraction_result_t predict_fraction(logic [3:0] m, longint an,
                                                          longint ad, longint bn, longint bd);
        fraction_result_t r;
        longint lhs;
        longint rhs;
        r = '0;
        lhs = an * bd;
        rhs = bn * ad;
        if (m <= rau_pkg::MODE_NE && (ad == 0 || bd == 0))
        begin
            r.err = 1'b1;
            return r;
        end
        case (m)
            rau_pkg::MODE_ADD: r = normalize(lhs + rhs, ad * bd);
            rau_pkg::MODE_SUB: r = normalize(lhs - rhs, ad * bd);
            rau_pkg::MODE_MUL: r = normalize(an * bn, ad * bd);
            rau_pkg::MODE_DIV: if (bn == 0) r.err = 1'b1; else r = normalize(lhs, ad * bn);
            rau_pkg::MODE_LT:  r.cmp = lhs < rhs;
            rau_pkg::MODE_GT:  r.cmp = lhs > rhs;
            rau_pkg::MODE_LE:  r.cmp = lhs <= rhs;
            rau_pkg::MODE_GE:  r.cmp = lhs >= rhs;
            rau_pkg::MODE_EQ:  r.cmp = lhs == rhs;
            rau_pkg::MODE_NE:  r.cmp = lhs != rhs;
            default:  ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk)
    begin
        fraction_result_t exp_r;
        if (rst_n)
        begin
            if (valid)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with no item outstanding");
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (res_num !== exp_r.num)
                        report_mismatch($sformatf("res_num %0d, want %0d", res_num,
                                                  $signed(exp_r.num)));
                    if (res_den !== exp_r.den)
                        report_mismatch($sformatf("res_den %0d, want %0d", res_den, exp_r.den));
                    if (cmp_true !== exp_r.cmp)
                        report_mismatch($sformatf("cmp_true %b, want %b", cmp_true, exp_r.cmp));
                    if (error !== exp_r.err)
                        report_mismatch($sformatf("error %b, want %b", error, exp_r.err));
                end
            end
            // Queue after the pop so a same-edge accept never matches itself.
            if (start && !busy)
                expected_results.push_back(predict_fraction(mode, a_num, a_den, b_num, b_den));
            if (finish_check && !leftovers_reported && expected_results.size() != 0)
            begin
                leftovers_reported = 1'b1;
                report_mismatch($sformatf("%0d results never came", expected_results.size()));
            end
        end
    end
endmodule

// File: verif/rational_arithmetic_unit_tb.sv
// Testbench top for the rational arithmetic unit: drives items, idles at
// random, and gives the verdict. Depends on rau_pkg, the unit and the checker module.
module rational_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [3:0]               mode;
    logic signed [15:0]       a_num;
    logic [14:0]              a_den;
    logic signed [15:0]       b_num;
    logic [14:0]              b_den;
    logic                     valid;
    logic signed [31:0]       res_num;
    logic [30:0]              res_den;
    logic                     cmp_true;
    logic                     error;
    logic                     finish_check;
    int                       fail_count;
    int                       pending;

    rational_arithmetic_unit dut (.*);

    rational_arithmetic_unit_checker checker_i (.*);

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick an operand numerator, leaning on the extremes and small values
    // so the reduction sees both large gcds and coprime pairs.
    function automatic logic [15:0] pick_num();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Denominators are rarely zero; the zero case is the error path.
    function automatic logic [14:0] pick_den();
        case ($urandom_range(0, 19))
            0:       return 15'd0;
            1:       return 15'h7fff;
            2, 3:    return 15'($urandom_range(1, 12));
            default: return 15'($urandom);
        endcase
    endfunction

    // Present one item at the falling edge and hold it until taken. Start
    // stays high on return; the block is busy after the
    // accept, so drop it before any idle time.
    task automatic send_item(logic [3:0] m, logic [15:0] an, logic [14:0] ad,
                             logic [15:0] bn, logic [14:0] bd);
        mode  <= m;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    // Drop start for a random idle burst.
    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
    endtask

    initial
    begin
        logic [3:0] m;
        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = rau_pkg::MODE_ADD;
        a_num        = '0;
        a_den        = 15'd1;
        b_num        = '0;
        b_den        = 15'd1;
        finish_check = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every mode on simple values, then the special cases.
        for (int i = 0; i <= int'(rau_pkg::MODE_NE); i++)
            send_item(4'(i), 16'sd3, 15'd4, -16'sd5, 15'd6);
        send_item(rau_pkg::MODE_ADD, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff);  // extremes
        send_item(rau_pkg::MODE_MUL, 16'h7fff, 15'd1, 16'h7fff, 15'd1);
        send_item(rau_pkg::MODE_DIV, 16'h8000, 15'd1, 16'h0001, 15'h7fff);
        send_item(rau_pkg::MODE_SUB, 16'sd2, 15'd3, 16'sd4, 15'd6);            // zero result
        send_item(rau_pkg::MODE_DIV, 16'sd1, 15'd2, 16'sd0, 15'd5);            // divide by zero
        send_item(rau_pkg::MODE_ADD, 16'sd1, 15'd0, 16'sd1, 15'd1);            // zero denominator
        send_item(rau_pkg::MODE_EQ, 16'sd1, 15'd1, 16'sd1, 15'd0);
        send_item(rau_pkg::MODE_EQ, 16'sd2, 15'd4, 16'sd1, 15'd2);             // equal by value
        send_item(4'd10, 16'sd1, 15'd0, 16'sd1, 15'd1);                        // unused modes
        send_item(4'd15, 16'hffff, 15'h7fff, 16'hffff, 15'h7fff);

        // Hold off until the block has drained everything.
        start <= 1'b0;
        wait (pending == 0);
        @(negedge clk);

        // Random items; the last part runs back to back.
        for (int n = 0; n < 1300; n++)
        begin
            if (n < 1150 && $urandom_range(0, 2) == 0)
                idle_burst();
            m = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            send_item(m, pick_num(), pick_den(), pick_num(), pick_den());
        end

        start <= 1'b0;
        wait (pending == 0);
        repeat (400) @(negedge clk);
        finish_check = 1'b1;
        @(negedge clk);
        if (fail_count == 0)
            $display("rational_arithmetic_unit_tb passed");
        else
            $display("rational_arithmetic_unit_tb failed");
        $finish;
    end

    // Watchdog: well above the slowest correct run.
    initial
    begin
        #100ms;
        $display("rational_arithmetic_unit_tb failed");
        $finish;
    end
endmodule
